### rtl/kmes_pkg.sv
// shared types and constants of the key matrix and encoder scanner
// no dependencies; imported by every module of the block
`default_nettype none

package kmes_pkg;

	// parameter defaults
	localparam int ROWS_DEF              = 4;
	localparam int COLS_DEF              = 4;
	localparam int MAX_VOLUME_EVENTS_DEF = 16;

	// hard limit of results per request
	localparam int RESULT_LIMIT = 16;

	// field widths
	localparam int ACTION_W = 2;
	localparam int ROW_W    = 2;
	localparam int COLBITS_W = 4;
	localparam int ENC_W    = 32;
	localparam int KIND_W   = 3;
	localparam int CODE_W   = 8;
	localparam int CPD_W    = 7;
	localparam int IDLE_W   = 24;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 8;

	// keymap registers cover four rows of four columns
	localparam int KEYMAP_ROWS = 4;
	localparam int KEYMAP_COLS = 4;

	// key that sends mute on press
	localparam int MUTE_ROW = 0;
	localparam int MUTE_COL = 3;

	// register reset values
	localparam logic [CFG_W-1:0]  KEYMAP0_RST = 32'hB1E9E8E7;
	localparam logic [CFG_W-1:0]  KEYMAP1_RST = 32'hDFE6E5E4;
	localparam logic [CFG_W-1:0]  KEYMAP2_RST = 32'hDEE3E2E1;
	localparam logic [CFG_W-1:0]  KEYMAP3_RST = 32'hE0B3EBEA;
	localparam logic [CPD_W-1:0]  CPD_RST     = 7'd2;
	localparam logic [IDLE_W-1:0] SLEEP_RST   = 24'd300000;
	localparam logic [IDLE_W-1:0] IDLE_MAX    = {IDLE_W{1'b1}};

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEYMAP0 = 3'd0,
		REG_KEYMAP1 = 3'd1,
		REG_KEYMAP2 = 3'd2,
		REG_KEYMAP3 = 3'd3,
		REG_CPD     = 3'd4,
		REG_SLEEP   = 3'd5
	} reg_idx_t;

	// request kinds
	typedef enum logic [ACTION_W-1:0] {
		ACT_SCAN = 2'd0,
		ACT_ENC  = 2'd1,
		ACT_TICK = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	// result kinds
	typedef enum logic [KIND_W-1:0] {
		EV_PRESS    = 3'd0,
		EV_RELEASE  = 3'd1,
		EV_MUTE     = 3'd2,
		EV_VOL_UP   = 3'd3,
		EV_VOL_DOWN = 3'd4,
		EV_SLEEP    = 3'd5
	} ev_kind_t;

	// controller to datapath
	typedef struct packed {
		logic load_scan;
		logic load_enc;
		logic load_tick;
		logic div_step;
		logic div_apply;
		logic emit_key;
		logic emit_vol;
		logic emit_sleep;
	} kmes_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_pending;
		logic div_last;
		logic vol_pending;
		logic sleep_hit;
		logic out_free;
	} kmes_sts_t;

endpackage

`default_nettype wire

### rtl/kmes_ctrl.sv
// controller state machine of the key matrix and encoder scanner
// depends on kmes_pkg; drives kmes_dp through command and status structs
`default_nettype none

module kmes_ctrl import kmes_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [ACTION_W-1:0] action,
	input  wire kmes_sts_t           sts,
	output kmes_cmd_t                cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_APPLY,
		ST_VOL,
		ST_SLEEP
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// commands and next state
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (action)
						ACT_SCAN: begin
							cmd.load_scan = 1'b1;
							state_nxt     = ST_SCAN;
						end
						ACT_ENC: begin
							cmd.load_enc = 1'b1;
							state_nxt    = ST_DIV;
						end
						ACT_TICK: begin
							cmd.load_tick = 1'b1;
							state_nxt     = ST_SLEEP;
						end
						default: state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (!sts.scan_pending) begin
					state_nxt = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.emit_key = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nxt = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.div_apply = 1'b1;
				state_nxt     = ST_VOL;
			end
			ST_VOL: begin
				if (!sts.vol_pending) begin
					state_nxt = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.emit_vol = 1'b1;
				end
			end
			ST_SLEEP: begin
				if (!sts.sleep_hit) begin
					state_nxt = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.emit_sleep = 1'b1;
					state_nxt      = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

### rtl/kmes_dp.sv
// datapath: config registers, key state, detent divider, idle counter, result register
// depends on kmes_pkg; sequenced by kmes_ctrl
`default_nettype none

module kmes_dp import kmes_pkg::*; #(
	parameter int ROWS              = ROWS_DEF,
	parameter int COLS              = COLS_DEF,
	parameter int MAX_VOLUME_EVENTS = MAX_VOLUME_EVENTS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_wdata,
	input  wire logic [ROW_W-1:0]      row,
	input  wire logic [COLBITS_W-1:0]  column_bits,
	input  wire logic [ENC_W-1:0]      encoder_count,
	input  wire kmes_cmd_t             cmd,
	output kmes_sts_t                  sts,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [KIND_W-1:0]          event_kind,
	output logic [CODE_W-1:0]          key_code,
	output logic                       last
);

	localparam int RIW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW  = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int CAP = (MAX_VOLUME_EVENTS < RESULT_LIMIT) ? MAX_VOLUME_EVENTS : RESULT_LIMIT;
	localparam int EW  = $clog2(CAP + 1);

	// config registers
	logic [CFG_W-1:0]  keymap_q [KEYMAP_ROWS];
	logic [CPD_W-1:0]  cpd_q;
	logic [IDLE_W-1:0] sleep_thr_q;

	// key state and scan work registers
	logic [COLS-1:0]  kp_q [ROWS];
	logic [ROW_W-1:0] row_q;
	logic [COLS-1:0]  new_q;
	logic [COLS-1:0]  chg_q;

	// encoder and divider registers
	logic [ENC_W-1:0]  enc_q;
	logic [ENC_W-1:0]  last_enc_q;
	logic              neg_q;
	logic [ENC_W-1:0]  quo_q;
	logic [CPD_W-1:0]  rem_q;
	logic [4:0]        dcnt_q;
	logic [EW-1:0]     evcnt_q;
	logic              vol_dn_q;

	// idle counter
	logic [IDLE_W-1:0] idle_q;
	logic              sleep_q;

	// result register
	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [CODE_W-1:0] code_q;
	logic              last_q;

	// scan decode
	logic                row_ok;
	logic [RIW-1:0]      ri;
	logic [11:0]         bits_wide;
	logic [COLS-1:0]     newb;
	logic [COLS-1:0]     oldb;
	logic [CW-1:0]       p;
	logic                found;
	logic [COLS-1:0]     rest;
	logic [1:0]          p2;
	logic                p_in_map;
	logic                is_mute;
	logic                now_pressed;
	logic [KIND_W-1:0]   key_kind;
	logic [CODE_W-1:0]   map_code;

	// encoder decode
	logic signed [ENC_W:0] diff;
	logic [ENC_W-1:0]      mag;
	logic [CPD_W-1:0]      divisor;
	logic [CPD_W:0]        trial;
	logic                  trial_ge;
	logic [CPD_W:0]        trial_sub;
	logic [ENC_W-1:0]      rem_ext;

	// idle decode
	logic [IDLE_W-1:0] idle_inc;
	logic              idle_hit;

	always_comb begin
		row_ok    = (int'(row) < ROWS);
		ri        = RIW'(row);
		bits_wide = {8'b0, column_bits};
		newb      = bits_wide[COLS-1:0];
		oldb      = kp_q[ri];
	end

	// lowest changed column
	always_comb begin
		p     = '0;
		found = 1'b0;
		for (int c = 0; c < COLS; c++) begin
			if (chg_q[c] && !found) begin
				p     = CW'(c);
				found = 1'b1;
			end
		end
		rest        = chg_q & ~(COLS'(1) << p);
		p2          = 2'(p);
		p_in_map    = (int'(p) < KEYMAP_COLS);
		now_pressed = new_q[p];
		is_mute     = now_pressed && (int'(row_q) == MUTE_ROW) && (int'(p) == MUTE_COL);
		map_code    = p_in_map ? keymap_q[row_q][8*p2 +: 8] : '0;
		if (!now_pressed) begin
			key_kind = EV_RELEASE;
		end else if (is_mute) begin
			key_kind = EV_MUTE;
		end else begin
			key_kind = EV_PRESS;
		end
	end

	// encoder difference and divider step
	always_comb begin
		diff      = $signed({encoder_count[ENC_W-1], encoder_count})
			- $signed({last_enc_q[ENC_W-1], last_enc_q});
		mag       = diff[ENC_W] ? ENC_W'(-diff) : diff[ENC_W-1:0];
		divisor   = (cpd_q == '0) ? CPD_W'(1) : cpd_q;
		trial     = {rem_q, quo_q[ENC_W-1]};
		trial_ge  = (trial >= {1'b0, divisor});
		trial_sub = trial - {1'b0, divisor};
		rem_ext   = {{(ENC_W-CPD_W){1'b0}}, rem_q};
	end

	// idle counter step
	always_comb begin
		idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 1'b1;
		idle_hit = (idle_inc > sleep_thr_q);
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keymap_q[0] <= KEYMAP0_RST;
			keymap_q[1] <= KEYMAP1_RST;
			keymap_q[2] <= KEYMAP2_RST;
			keymap_q[3] <= KEYMAP3_RST;
			cpd_q       <= CPD_RST;
			sleep_thr_q <= SLEEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEYMAP0: keymap_q[0] <= cfg_wdata;
				REG_KEYMAP1: keymap_q[1] <= cfg_wdata;
				REG_KEYMAP2: keymap_q[2] <= cfg_wdata;
				REG_KEYMAP3: keymap_q[3] <= cfg_wdata;
				REG_CPD:     cpd_q       <= cfg_wdata[CPD_W-1:0];
				REG_SLEEP:   sleep_thr_q <= cfg_wdata[IDLE_W-1:0];
				default: ;
			endcase
		end
	end

	// key state, encoder position, idle counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				kp_q[r] <= '0;
			end
			chg_q      <= '0;
			last_enc_q <= '0;
			idle_q     <= '0;
			sleep_q    <= 1'b0;
			evcnt_q    <= '0;
			dcnt_q     <= '0;
		end else begin
			if (cmd.load_scan) begin
				if (row_ok) begin
					kp_q[ri] <= newb;
					chg_q    <= newb ^ oldb;
					if (|(newb & ~oldb)) begin
						idle_q <= '0;
					end
				end else begin
					chg_q <= '0;
				end
			end
			if (cmd.emit_key) begin
				chg_q <= rest;
			end
			if (cmd.load_enc) begin
				dcnt_q <= '0;
			end
			if (cmd.div_step) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (cmd.div_apply) begin
				if (quo_q != '0) begin
					idle_q     <= '0;
					last_enc_q <= neg_q ? enc_q + rem_ext : enc_q - rem_ext;
					evcnt_q    <= (quo_q > ENC_W'(CAP)) ? EW'(CAP) : EW'(quo_q);
				end else begin
					evcnt_q <= '0;
				end
			end
			if (cmd.emit_vol) begin
				evcnt_q <= evcnt_q - 1'b1;
			end
			if (cmd.load_tick) begin
				sleep_q <= idle_hit;
				idle_q  <= idle_hit ? '0 : idle_inc;
			end
		end
	end

	// scan and divider work registers
	always_ff @(posedge clk) begin
		if (cmd.load_scan) begin
			row_q <= row;
			new_q <= newb;
		end
		if (cmd.load_enc) begin
			enc_q <= encoder_count;
			neg_q <= diff[ENC_W];
			quo_q <= mag;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			quo_q <= {quo_q[ENC_W-2:0], trial_ge};
			rem_q <= trial_ge ? trial_sub[CPD_W-1:0] : trial[CPD_W-1:0];
		end
		if (cmd.div_apply) begin
			vol_dn_q <= neg_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_key || cmd.emit_vol || cmd.emit_sleep) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_key) begin
			kind_q <= key_kind;
			code_q <= is_mute ? '0 : map_code;
			last_q <= (rest == '0);
		end else if (cmd.emit_vol) begin
			kind_q <= vol_dn_q ? EV_VOL_DOWN : EV_VOL_UP;
			code_q <= '0;
			last_q <= (evcnt_q == EW'(1));
		end else if (cmd.emit_sleep) begin
			kind_q <= EV_SLEEP;
			code_q <= '0;
			last_q <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = kind_q;
	assign key_code   = code_q;
	assign last       = last_q;

	always_comb begin
		sts.scan_pending = |chg_q;
		sts.div_last     = &dcnt_q;
		sts.vol_pending  = (evcnt_q != '0);
		sts.sleep_hit    = sleep_q;
		sts.out_free     = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

### rtl/key_matrix_encoder_scanner.sv
// key matrix and rotary encoder scanner, top level
// one request at a time: a row scan emits a result per changed column, an encoder sample
// runs the 32-step detent divider and then emits its volume events, a tick at most a sleep event
// results come out of a registered output; a receiver stall holds the next result back
// reset: asynchronous, restores keymap, detent and threshold defaults, clears key state
// depends on kmes_pkg, kmes_ctrl, kmes_dp
`default_nettype none

module key_matrix_encoder_scanner import kmes_pkg::*; #(
	parameter int ROWS              = ROWS_DEF,
	parameter int COLS              = COLS_DEF,
	parameter int MAX_VOLUME_EVENTS = MAX_VOLUME_EVENTS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_wdata,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// row [1:0], column_bits [5:2], encoder_count [37:6], zero fill
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// action [1:0]
	input  wire logic [ACTION_W-1:0]   s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// key_code [7:0]
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// event_kind [2:0]
	output logic [KIND_W-1:0]          m_tuser,
	output logic                       m_tlast
);

	kmes_cmd_t         cmd;
	kmes_sts_t         sts;

	kmes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.action   (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	kmes_dp #(
		.ROWS              (ROWS),
		.COLS              (COLS),
		.MAX_VOLUME_EVENTS (MAX_VOLUME_EVENTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.row           (s_tdata[1:0]),
		.column_bits   (s_tdata[5:2]),
		.encoder_count (s_tdata[37:6]),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.event_kind    (m_tuser),
		.key_code      (m_tdata),
		.last          (m_tlast)
	);

endmodule

`default_nettype wire

### tb/sv/tb.sv
// self-checking testbench of the key matrix and encoder scanner
// predicts events per request in-line and compares each streamed result
// depends on kmes_pkg and key_matrix_encoder_scanner
`timescale 1ns / 100ps

module tb import kmes_pkg::*; ;

	localparam int DRAIN_CYCLES   = 60;
	localparam int SETTLE_CYCLES  = 100;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int VOL_CAP = (MAX_VOLUME_EVENTS_DEF < RESULT_LIMIT) ?
		MAX_VOLUME_EVENTS_DEF : RESULT_LIMIT;

	typedef struct {
		ev_kind_t   kind;
		logic [7:0] code;
		logic       last;
	} key_event_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// row [1:0], column_bits [5:2], encoder_count [37:6], zero fill
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	// action [1:0]
	logic [ACTION_W-1:0]   s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// key_code [7:0]
	logic [OUT_DATA_W-1:0] m_tdata;
	// event_kind [2:0]
	logic [KIND_W-1:0]     m_tuser;
	logic                  m_tlast;

	// predictor copy of registers and state
	logic [31:0] keymap_cfg [4];
	logic [6:0]  detent_cfg;
	logic [23:0] sleep_cfg;
	logic [3:0]  key_state [4];
	longint      enc_pos;
	logic [23:0] idle_count;

	key_event_t expected_events [$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	key_matrix_encoder_scanner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #5 clk = ~clk;

	// receiver stalls
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		key_event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_events.size() == 0) begin
				$display("%0t: expected no result, got kind %0d code 0x%02h last %0d",
					$time, m_tuser, m_tdata, m_tlast);
				mismatch_count++;
			end else begin
				want = expected_events.pop_front();
				if (m_tuser !== want.kind || m_tdata !== want.code ||
						m_tlast !== want.last) begin
					$display("%0t: expected kind %0d code 0x%02h last %0d, got kind %0d code 0x%02h last %0d",
						$time, want.kind, want.code, want.last,
						m_tuser, m_tdata, m_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// stop the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// events that one request causes
	function automatic void predict_events(action_t act, logic [1:0] row,
			logic [3:0] cols, logic [31:0] enc);
		key_event_t batch [$];
		key_event_t ev;
		logic       now_on;
		logic       was_on;
		longint     divisor;
		longint     steps;
		longint     mag;
		ev.last = 1'b0;
		case (act)
			ACT_SCAN: begin
				for (int c = 0; c < KEYMAP_COLS; c++) begin
					now_on = cols[c];
					was_on = key_state[row][c];
					if (now_on && !was_on) begin
						if (row == MUTE_ROW && c == MUTE_COL) begin
							ev.kind = EV_MUTE;
							ev.code = 8'h00;
						end else begin
							ev.kind = EV_PRESS;
							ev.code = keymap_cfg[row][8*c +: 8];
						end
						batch.push_back(ev);
						idle_count = '0;
					end else if (!now_on && was_on) begin
						ev.kind = EV_RELEASE;
						ev.code = keymap_cfg[row][8*c +: 8];
						batch.push_back(ev);
					end
					key_state[row][c] = now_on;
				end
			end
			ACT_ENC: begin
				divisor = (detent_cfg == 0) ? 1 : longint'(detent_cfg);
				steps = (longint'($signed(enc)) - enc_pos) / divisor;
				if (steps != 0) begin
					idle_count = '0;
					enc_pos += steps * divisor;
					mag = (steps < 0) ? -steps : steps;
					if (mag > VOL_CAP)
						mag = VOL_CAP;
					ev.kind = (steps > 0) ? EV_VOL_UP : EV_VOL_DOWN;
					ev.code = 8'h00;
					for (longint i = 0; i < mag; i++)
						batch.push_back(ev);
				end
			end
			ACT_TICK: begin
				if (idle_count != IDLE_MAX)
					idle_count++;
				if (idle_count > sleep_cfg) begin
					ev.kind = EV_SLEEP;
					ev.code = 8'h00;
					batch.push_back(ev);
					idle_count = '0;
				end
			end
			default: ;
		endcase
		if (batch.size() > 0)
			batch[batch.size()-1].last = 1'b1;
		foreach (batch[i])
			expected_events.push_back(batch[i]);
	endfunction

	// one request, with a random gap ahead of it
	task automatic send_request(action_t act, logic [1:0] row, logic [3:0] cols,
			logic [31:0] enc);
		int gap;
		gap = 0;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {{(IN_DATA_W-38){1'b0}}, enc, cols, row};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_events(act, row, cols, enc);
	endtask

	// hold requests until every predicted event is out and the block is idle
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	// write all six registers while idle
	task automatic load_settings(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
			logic [31:0] k3, logic [6:0] cpd, logic [23:0] thr);
		drain_block();
		write_reg(REG_KEYMAP0, k0);
		write_reg(REG_KEYMAP1, k1);
		write_reg(REG_KEYMAP2, k2);
		write_reg(REG_KEYMAP3, k3);
		write_reg(REG_CPD, {{(CFG_W-CPD_W){1'b0}}, cpd});
		write_reg(REG_SLEEP, {{(CFG_W-IDLE_W){1'b0}}, thr});
		cfg_we <= 1'b0;
		keymap_cfg[0] = k0;
		keymap_cfg[1] = k1;
		keymap_cfg[2] = k2;
		keymap_cfg[3] = k3;
		detent_cfg = cpd;
		sleep_cfg = thr;
	endtask

	// presses, releases and the mute key at reset keymaps
	task automatic test_key_scan();
		send_request(ACT_SCAN, 2'd0, 4'hF, 32'h0);
		send_request(ACT_SCAN, 2'd0, 4'h0, 32'h0);
		send_request(ACT_SCAN, 2'd1, 4'h5, 32'h0);
		send_request(ACT_SCAN, 2'd1, 4'hA, 32'h0);
		send_request(ACT_SCAN, 2'd2, 4'hF, 32'h0);
		send_request(ACT_SCAN, 2'd3, 4'hF, 32'h0);
		send_request(ACT_SCAN, 2'd2, 4'h0, 32'h0);
		send_request(ACT_SCAN, 2'd3, 4'h0, 32'h0);
	endtask

	// partial detents, truncation toward zero, capped event bursts
	task automatic test_encoder();
		send_request(ACT_ENC, 2'd0, 4'h0, 32'd1);
		send_request(ACT_ENC, 2'd0, 4'h0, 32'd2);
		send_request(ACT_ENC, 2'd0, 4'h0, -32'sd3);
		send_request(ACT_ENC, 2'd0, 4'h0, 32'h7FFF_FFFF);
		send_request(ACT_ENC, 2'd0, 4'h0, 32'h8000_0000);
	endtask

	// idle counter, sleep events and ignored requests
	task automatic test_idle_sleep();
		load_settings(KEYMAP0_RST, KEYMAP1_RST, KEYMAP2_RST, KEYMAP3_RST, CPD_RST, 24'd2);
		repeat (4) send_request(ACT_TICK, 2'd0, 4'h0, 32'h0);
		send_request(ACT_SCAN, 2'd2, 4'h2, 32'h0);
		repeat (3) send_request(ACT_TICK, 2'd0, 4'h0, 32'h0);
		send_request(ACT_NONE, 2'd3, 4'hF, 32'hFFFF_FFFF);
		load_settings(KEYMAP0_RST, KEYMAP1_RST, KEYMAP2_RST, KEYMAP3_RST, CPD_RST, 24'd0);
		repeat (2) send_request(ACT_TICK, 2'd0, 4'h0, 32'h0);
	endtask

	// register extremes: empty and full keymaps, detent sizes, thresholds
	task automatic test_config_extremes();
		load_settings(32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_00FF, 32'hA5A5_5A5A,
			7'd0, 24'd0);
		send_request(ACT_SCAN, 2'd1, 4'hF, 32'h0);
		send_request(ACT_SCAN, 2'd0, 4'h7, 32'h0);
		send_request(ACT_ENC, 2'd0, 4'h0, 32'(enc_pos + 3));
		load_settings(32'hFFFF_FFFF, 32'h0000_0000, 32'h1234_5678, 32'hFEDC_BA98,
			7'd127, 24'hFF_FFFF);
		send_request(ACT_SCAN, 2'd1, 4'h0, 32'h0);
		send_request(ACT_ENC, 2'd0, 4'h0, 32'(enc_pos + 381));
		send_request(ACT_ENC, 2'd0, 4'h0, 32'(enc_pos - 126));
		send_request(ACT_TICK, 2'd0, 4'h0, 32'h0);
	endtask

	// mostly plausible key and knob activity, some arbitrary noise
	task automatic run_random_phase(int count);
		int         pick;
		int         span;
		logic [1:0] row;
		logic [3:0] cols;
		logic [31:0] enc;
		load_settings($urandom, $urandom, $urandom, $urandom,
			7'($urandom_range(1, 9)), 24'($urandom_range(1, 15)));
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			row  = 2'($urandom_range(3));
			if (pick < 45) begin
				if ($urandom_range(1) == 1)
					cols = key_state[row] ^ (4'h1 << $urandom_range(3));
				else
					cols = 4'($urandom_range(15));
				send_request(ACT_SCAN, row, cols, $urandom);
			end else if (pick < 70) begin
				span = ((detent_cfg == 0) ? 1 : int'(detent_cfg)) * 20;
				if ($urandom_range(9) == 0)
					enc = $urandom;
				else
					enc = 32'(enc_pos + $urandom_range(0, 2 * span) - span);
				send_request(ACT_ENC, row, 4'($urandom_range(15)), enc);
			end else if (pick < 96) begin
				send_request(ACT_TICK, row, 4'($urandom_range(15)), $urandom);
			end else begin
				send_request(ACT_NONE, row, 4'($urandom_range(15)), $urandom);
			end
		end
	endtask

	task automatic test_random_traffic();
		send_idle_pct = 37;
		recv_idle_pct = 77;
		run_random_phase(170);
		send_idle_pct = 77;
		recv_idle_pct = 37;
		run_random_phase(170);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random_phase(160);
	endtask

	initial begin
		keymap_cfg[0] = KEYMAP0_RST;
		keymap_cfg[1] = KEYMAP1_RST;
		keymap_cfg[2] = KEYMAP2_RST;
		keymap_cfg[3] = KEYMAP3_RST;
		detent_cfg = CPD_RST;
		sleep_cfg = SLEEP_RST;
		foreach (key_state[i])
			key_state[i] = '0;
		enc_pos = 0;
		idle_count = '0;
		send_idle_pct = 37;
		recv_idle_pct = 77;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_key_scan();
		test_encoder();
		test_idle_sleep();
		test_config_extremes();
		test_random_traffic();

		s_tvalid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_events.size() != 0) begin
			$display("%0t: %0d predicted events never arrived", $time,
				expected_events.size());
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
